@@ hdl/sha1md_pkg.sv @@
// shared types and constants of the sha-1 message digest block
`default_nettype none

package sha1md_pkg;

	// a..e working words, also used for the five chaining words h0..h4
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	localparam work_t CHAIN_INIT = '{
		a: 32'h67452301,
		b: 32'hEFCDAB89,
		c: 32'h98BADCFE,
		d: 32'h10325476,
		e: 32'hC3D2E1F0
	};

	localparam logic [31:0] K_CH  = 32'h5A827999;
	localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
	localparam logic [31:0] K_XOR = 32'hCA62C1D6;

	localparam logic [6:0] ROUND_CH_END  = 7'd20;
	localparam logic [6:0] ROUND_PAR_END = 7'd40;
	localparam logic [6:0] ROUND_MAJ_END = 7'd60;
	localparam logic [6:0] ROUND_LAST    = 7'd79;

	localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

`default_nettype wire

@@ hdl/sha1md_round.sv @@
// one sha-1 compression round, reused for all 80 rounds of a block
`default_nettype none

module sha1md_round (
	input  wire sha1md_pkg::work_t cur,
	input  wire logic [31:0]       w,
	input  wire logic [6:0]        t,
	output sha1md_pkg::work_t      nxt
);

	logic [31:0] f;
	logic [31:0] k;

	always_comb begin
		if (t < sha1md_pkg::ROUND_CH_END) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = sha1md_pkg::K_CH;
		end else if (t < sha1md_pkg::ROUND_PAR_END) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1md_pkg::K_PAR;
		end else if (t < sha1md_pkg::ROUND_MAJ_END) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = sha1md_pkg::K_MAJ;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1md_pkg::K_XOR;
		end
	end

	always_comb begin
		nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

`default_nettype wire

@@ hdl/sha1_message_digest.sv @@
// top level of the sha-1 message digest block
//
//  channel  dir  tdata                      tuser          tlast
//  s_axis   in   [7:0] data_byte            byte_present   last
//  m_axis   out  [159:0] h0 (low) .. h4     -              -
//
// a message byte is taken and shifted into the 512-bit block
// register; the 64th byte of a block starts the compression, which runs
// 80 rounds through one shared round unit, then a finish step folds the
// result into the chaining words.
// after last the pad, zero and length bytes (one or two blocks) are shifted in
// one per cycle outside compression, then the digest is loaded into the output register.
// arst_n clears the sequencer and restores the initial chaining words.
// a waiting digest does not block new bytes; only a second finished digest
// waits in the finish state until the first transfer has gone out.
`default_nettype none

module sha1_message_digest (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  wire logic         s_axis_tuser,   // [0] byte_present
	input  wire logic         s_axis_tlast,   // last byte of the message
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [159:0]      m_axis_tdata    // h0, h1, h2, h3, h4 from bit 0 up
);

	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] LEN_POS   = 6'd56;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_ROUND,
		ST_FINISH,
		ST_PAD
	} state_t;

	state_t            state_q;
	logic [5:0]        fill_q;        // bytes in the current block
	logic [60:0]       cnt_q;         // message bytes
	logic [6:0]        round_q;
	logic              pad_first_q;   // next pad byte is the 0x80 marker
	logic              len_ok_q;      // length field fits in this block
	logic              final_q;       // running compression is the last one
	logic              resume_pad_q;  // padding continues after compression
	logic              out_valid_q;
	logic [159:0]      out_data_q;
	logic [511:0]      blk_q;         // block register, word 0 on top
	sha1md_pkg::work_t chain_q;
	sha1md_pkg::work_t work_q;

	logic              in_take;
	logic              push_en;
	logic [7:0]        push_byte;
	logic [7:0]        pad_byte;
	logic              start_comp;
	logic              can_load;
	logic              load_out;
	logic [63:0]       len_bits;
	logic [31:0]       w_cur;
	logic [31:0]       sched_mix;
	logic [31:0]       sched_new;
	sha1md_pkg::work_t round_nxt;
	sha1md_pkg::work_t sums;

	sha1md_round u_round (
		.cur (work_q),
		.w   (w_cur),
		.t   (round_q),
		.nxt (round_nxt)
	);

	// message schedule taps on the shifting window: w[t], w[t+2], w[t+8], w[t+13]
	assign w_cur     = blk_q[511:480];
	assign sched_mix = blk_q[511:480] ^ blk_q[447:416] ^ blk_q[255:224] ^ blk_q[95:64];
	assign sched_new = {sched_mix[30:0], sched_mix[31]};

	assign len_bits = {cnt_q, 3'b000};

	always_comb begin
		if (pad_first_q) begin
			pad_byte = sha1md_pkg::PAD_BYTE;
		end else if (len_ok_q && (fill_q >= LEN_POS)) begin
			// length goes out most significant byte first
			pad_byte = len_bits[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign s_axis_tready = (state_q == ST_COLLECT);
	assign in_take       = s_axis_tvalid & s_axis_tready;
	assign push_en       = (in_take & s_axis_tuser) | (state_q == ST_PAD);
	assign push_byte     = (state_q == ST_PAD) ? pad_byte : s_axis_tdata;
	assign start_comp    = push_en & (fill_q == FILL_LAST);
	assign can_load      = ~out_valid_q | m_axis_tready;
	assign load_out      = (state_q == ST_FINISH) & final_q & can_load;

	always_comb begin
		sums.a = chain_q.a + work_q.a;
		sums.b = chain_q.b + work_q.b;
		sums.c = chain_q.c + work_q.c;
		sums.d = chain_q.d + work_q.d;
		sums.e = chain_q.e + work_q.e;
	end

	// sequencer, counters, chaining words and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_COLLECT;
			fill_q       <= '0;
			cnt_q        <= '0;
			round_q      <= '0;
			pad_first_q  <= 1'b0;
			len_ok_q     <= 1'b0;
			final_q      <= 1'b0;
			resume_pad_q <= 1'b0;
			out_valid_q  <= 1'b0;
			chain_q      <= sha1md_pkg::CHAIN_INIT;
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_COLLECT: begin
					if (in_take) begin
						if (s_axis_tuser) begin
							cnt_q <= cnt_q + 61'd1;
						end
						if (s_axis_tlast) begin
							pad_first_q <= 1'b1;
							len_ok_q    <= 1'b0;
						end
						if (start_comp) begin
							final_q      <= 1'b0;
							resume_pad_q <= s_axis_tlast;
							state_q      <= ST_ROUND;
						end else if (s_axis_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					if (start_comp) begin
						final_q      <= len_ok_q & ~pad_first_q;
						resume_pad_q <= 1'b1;
						len_ok_q     <= 1'b1;
						state_q      <= ST_ROUND;
					end else if (pad_first_q) begin
						len_ok_q <= (fill_q < LEN_POS);
					end
				end
				ST_ROUND: begin
					if (round_q == sha1md_pkg::ROUND_LAST) begin
						round_q <= '0;
						state_q <= ST_FINISH;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				ST_FINISH: begin
					if (!final_q) begin
						chain_q <= sums;
						state_q <= resume_pad_q ? ST_PAD : ST_COLLECT;
					end else if (can_load) begin
						chain_q <= sha1md_pkg::CHAIN_INIT;
						cnt_q   <= '0;
						state_q <= ST_COLLECT;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	// block register, working words and digest register
	always_ff @(posedge clk) begin
		if (push_en) begin
			blk_q <= {blk_q[503:0], push_byte};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[479:0], sched_new};
		end
		if (start_comp) begin
			work_q <= chain_q;
		end else if (state_q == ST_ROUND) begin
			work_q <= round_nxt;
		end
		if (load_out) begin
			out_data_q <= {sums.e, sums.d, sums.c, sums.b, sums.a};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

@@ hdl/sha1md_checker.sv @@
// port-level checks of the sha-1 message digest block and their binding
`default_nettype none

module sha1md_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         s_axis_tlast,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [159:0] m_axis_tdata
);

	// a digest waits until its transfer completes
	a_out_hold : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("digest dropped before transfer");

	a_out_stable : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("digest changed while stalled");

	// the end of a message starts padding or a compression, so input stalls next cycle
	a_last_stalls : assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken right after the last byte");

	// a new digest only comes out of the finish step, when input is stalled
	a_digest_after_work : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("digest appeared without a compression");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (.*);

`default_nettype wire
